/* rtl/sptla_pkg.sv */
// Shared types, constants and the switch decode for the step program table.
package sptla_pkg;

    localparam int WORD_W        = 15;
    localparam int STEP_W        = 4;
    localparam int LINES_W       = 32;
    localparam int DEF_STEPS     = 16;
    localparam int DEF_SECTIONS  = 2;

    localparam logic [WORD_W-1:0] RESET_WORD    = 15'h4000;
    localparam logic [STEP_W-1:0] LAST_STEP_RST = 4'd15;

    localparam int FIRST_BIT = 10;
    localparam int LAST_BIT  = 11;

    localparam logic CMD_PROG = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic               section;
        logic [STEP_W-1:0]  step;
        logic [LINES_W-1:0] switch_lines;
    } req_t;

    typedef struct packed {
        logic [STEP_W-1:0] follow_step;
        logic [WORD_W-1:0] step_word;
    } rsp_t;

    typedef struct packed {
        logic [STEP_W-1:0] last_step;
    } cfg_t;

    // Apply active-low switches in bit order; later switches override earlier ones.
    function automatic logic [WORD_W-1:0] program_word(
        input logic [WORD_W-1:0]  w,
        input logic [LINES_W-1:0] lines
    );
        logic [LINES_W-1:0] act;
        logic [2:0]         vr;
        logic               p1;
        logic               p2;
        logic               qn;
        logic               sl;
        logic               vs;
        logic [1:0]         op;
        logic               fst;
        logic               lst;
        logic               ts;
        logic [1:0]         tr;
        act = ~lines;
        vr  = w[2:0];
        p1  = w[3];
        p2  = w[4];
        qn  = w[5];
        sl  = w[6];
        vs  = w[7];
        op  = w[9:8];
        fst = w[10];
        lst = w[11];
        ts  = w[12];
        tr  = w[14:13];
        for (int i = 0; i < 5; i++)
        begin
            if (act[i])
            begin
                vr = 3'(i + 1);
            end
        end
        if (act[5])  vr = 3'd0;
        if (act[6])  p1 = 1'b1;
        if (act[7])  p1 = 1'b0;
        if (act[8])  p2 = 1'b1;
        if (act[9])  p2 = 1'b0;
        if (act[10]) qn = 1'b1;
        if (act[11]) qn = 1'b0;
        if (act[12]) sl = 1'b1;
        if (act[13]) sl = 1'b0;
        if (act[14]) vs = 1'b1;
        if (act[15]) vs = 1'b0;
        // stop / sustain / enable: off only clears its own mode
        for (int i = 0; i < 3; i++)
        begin
            if (act[16 + 2 * i])
            begin
                op = 2'(i + 1);
            end
            if (act[17 + 2 * i] && op == 2'(i + 1))
            begin
                op = 2'd0;
            end
        end
        if (act[22])
        begin
            fst = 1'b1;
            lst = 1'b0;
        end
        if (act[23]) fst = 1'b0;
        if (act[24])
        begin
            lst = 1'b1;
            fst = 1'b0;
        end
        if (act[25]) lst = 1'b0;
        if (act[26]) ts = 1'b1;
        if (act[27]) ts = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (act[28 + i])
            begin
                tr = 2'(i);
            end
        end
        return {tr, ts, lst, fst, op, vs, sl, qn, p2, p1, vr};
    endfunction

endpackage

/* rtl/sptla_chan_if.sv */
// Valid/ready channel carrying one payload item.
interface sptla_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/step_program_table_with_loop_advance_top.sv */
// Top level: step flag table with switch programming and loop-aware step advance.
//
//  channel | dir | payload                               | accepted when
//  --------+-----+---------------------------------------+----------------------
//  req     | in  | cmd, section, step, switch_lines      | req.valid & req.ready
//  rsp     | out | follow_step, step_word                | rsp.valid & rsp.ready
//  cfg     | in  | last_step                             | cfg.valid & cfg.ready
//
// One item at a time. Program and plain advance: the accepted item issues the
// memory read in S_IDLE; S_LOOKUP takes the read word and registers the result.
// Advance from a step marked last walks back one step per memory read, from
// the addressed step down to the nearest first mark, or to step 0 if none.
// The flag memory's single read port sets that search rate.
// Reset: per-entry valid bits make unwritten steps read as the reset word;
// no clearing pass. A result waiting on rsp does not block the next accept;
// the block only holds before writing its result while the output is full.
module step_program_table_with_loop_advance_top #(
    parameter int STEPS_PER_SECTION = sptla_pkg::DEF_STEPS,
    parameter int SECTIONS          = sptla_pkg::DEF_SECTIONS
) (
    input  logic         clk,
    input  logic         rst_n,
    sptla_chan_if.sink   req,
    sptla_chan_if.source rsp,
    sptla_chan_if.sink   cfg
);
    import sptla_pkg::*;

    localparam int DEPTH  = SECTIONS * STEPS_PER_SECTION;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SEARCH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rsp_t               out_data_reg;
    rsp_t               out_data_next;
    logic [STEP_W-1:0]  last_step_reg;

    logic               cmd_reg;
    logic               cmd_next;
    logic               sec_reg;
    logic               sec_next;
    logic [STEP_W-1:0]  st_reg;
    logic [STEP_W-1:0]  st_next;
    logic [LINES_W-1:0] lines_reg;
    logic [LINES_W-1:0] lines_next;
    logic [STEP_W-1:0]  nxt_reg;
    logic [STEP_W-1:0]  nxt_next;
    logic [WORD_W-1:0]  word_reg;
    logic [WORD_W-1:0]  word_next;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_word;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  prog_word;

    logic               sec_in;
    logic [STEP_W-1:0]  st_in;
    logic [STEP_W:0]    inc;
    logic [STEP_W-1:0]  adv_step;
    logic               can_out;

    // step modulo section size by repeated compare-subtract (4-bit value)
    function automatic logic [STEP_W-1:0] step_mod(input logic [STEP_W-1:0] v);
        logic [6:0] r;
        r = 7'(v);
        for (int i = 0; i < 8; i++)
        begin
            if (r >= 7'(STEPS_PER_SECTION))
            begin
                r = r - 7'(STEPS_PER_SECTION);
            end
        end
        return r[STEP_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic              sec,
        input logic [STEP_W-1:0] st
    );
        return ADDR_W'(st) + (sec ? ADDR_W'(STEPS_PER_SECTION) : ADDR_W'(0));
    endfunction

    sptla_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_word (rd_word),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_word (prog_word)
    );

    assign sec_in    = (SECTIONS > 1) ? req.data.section : 1'b0;
    assign st_in     = step_mod(req.data.step);
    assign prog_word = program_word(rd_word, lines_reg);
    assign wr_addr   = addr_of(sec_reg, st_reg);

    // plain advance with wrap past last_step or section end
    assign inc      = {1'b0, st_reg} + (STEP_W+1)'(1);
    assign adv_step = (inc > {1'b0, last_step_reg} || 7'(inc) >= 7'(STEPS_PER_SECTION))
                      ? '0 : inc[STEP_W-1:0];

    assign can_out   = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        cmd_next       = cmd_reg;
        sec_next       = sec_reg;
        st_next        = st_reg;
        lines_next     = lines_reg;
        nxt_next       = nxt_reg;
        word_next      = word_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_of(sec_reg, st_reg);
        wr_en          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.data.cmd;
                    sec_next   = sec_in;
                    st_next    = st_in;
                    lines_next = req.data.switch_lines;
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(sec_in, st_in);
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (cmd_reg == CMD_NEXT && rd_word[LAST_BIT])
                begin
                    // start the backward walk at the addressed step itself
                    word_next  = rd_word;
                    nxt_next   = st_reg;
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(sec_reg, st_reg);
                    state_next = S_SEARCH;
                end
                else if (can_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (cmd_reg == CMD_PROG)
                    begin
                        wr_en                     = 1'b1;
                        out_data_next.follow_step = st_reg;
                        out_data_next.step_word   = prog_word;
                    end
                    else
                    begin
                        out_data_next.follow_step = adv_step;
                        out_data_next.step_word   = rd_word;
                    end
                end
            end
            S_SEARCH:
            begin
                if (nxt_reg == '0 || rd_word[FIRST_BIT])
                begin
                    if (can_out)
                    begin
                        out_valid_next            = 1'b1;
                        out_data_next.follow_step = nxt_reg;
                        out_data_next.step_word   = word_reg;
                        state_next                = S_IDLE;
                    end
                end
                else
                begin
                    nxt_next = nxt_reg - STEP_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = addr_of(sec_reg, nxt_reg - STEP_W'(1));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_step_reg <= LAST_STEP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                last_step_reg <= cfg.data.last_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        cmd_reg      <= cmd_next;
        sec_reg      <= sec_next;
        st_reg       <= st_next;
        lines_reg    <= lines_next;
        nxt_reg      <= nxt_next;
        word_reg     <= word_next;
    end

`ifndef SYNTHESIS
    a_wr_only_program: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_LOOKUP && cmd_reg == CMD_PROG))
        else $error("flag write outside program lookup");

    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("memory read and write in the same cycle");

    a_search_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (nxt_reg <= st_reg))
        else $error("backward search passed the addressed step");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_LOOKUP))
        else $error("accepted item did not start a lookup");

    a_search_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && state_next == S_SEARCH && nxt_next != nxt_reg)
        |-> rd_en)
        else $error("search stepped without a memory read");
`endif

endmodule

/* rtl/sptla_store.sv */
// Flag word memory with registered read and per-entry valid bits.
module sptla_store #(
    parameter int DEPTH  = sptla_pkg::DEF_STEPS * sptla_pkg::DEF_SECTIONS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [sptla_pkg::WORD_W-1:0]  rd_word,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [sptla_pkg::WORD_W-1:0]  wr_word
);
    import sptla_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // never-written entries read as the reset word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_vld_reg ? rd_data_reg : RESET_WORD;

endmodule

/* sim/testbench.sv */
// Testbench for the step program table: random and directed items checked against a predictor.
`timescale 1ns / 1ps

// Keeps its own copy of the flag table and last_step; predicts each result.
class step_table_tracker;
    logic [sptla_pkg::WORD_W-1:0] flags [32];
    logic [sptla_pkg::STEP_W-1:0] last_step;
    sptla_pkg::rsp_t              awaited [$];
    int                           errors;

    function new();
        foreach (flags[i])
        begin
            flags[i] = sptla_pkg::RESET_WORD;
        end
        last_step = sptla_pkg::LAST_STEP_RST;
        errors    = 0;
    endfunction

    // Switches in bit order, pressed = 0; a later press overrides an earlier one.
    function logic [14:0] apply_switches(logic [14:0] w, logic [31:0] lines);
        logic [31:0] pressed;
        pressed = ~lines;
        for (int i = 0; i < 5; i++)
        begin
            if (pressed[i])
            begin
                w[2:0] = 3'(i + 1);
            end
        end
        if (pressed[5]) w[2:0] = 3'd0;
        // on/off pairs 6..15 drive flag bits 3..7
        for (int k = 0; k < 5; k++)
        begin
            if (pressed[6 + 2 * k]) w[3 + k] = 1'b1;
            if (pressed[7 + 2 * k]) w[3 + k] = 1'b0;
        end
        // stop, sustain, enable: an off press clears only its own mode
        for (int m = 0; m < 3; m++)
        begin
            if (pressed[16 + 2 * m]) w[9:8] = 2'(m + 1);
            if (pressed[17 + 2 * m] && w[9:8] == 2'(m + 1)) w[9:8] = 2'd0;
        end
        if (pressed[22])
        begin
            w[10] = 1'b1;
            w[11] = 1'b0;
        end
        if (pressed[23]) w[10] = 1'b0;
        if (pressed[24])
        begin
            w[11] = 1'b1;
            w[10] = 1'b0;
        end
        if (pressed[25]) w[11] = 1'b0;
        if (pressed[26]) w[12] = 1'b1;
        if (pressed[27]) w[12] = 1'b0;
        for (int t = 0; t < 4; t++)
        begin
            if (pressed[28 + t]) w[14:13] = 2'(t);
        end
        return w;
    endfunction

    // Accepted request: update the table and queue the result it must give.
    function void note_req(sptla_pkg::req_t r);
        logic [4:0]      idx;
        logic [4:0]      base;
        logic [4:0]      nxt;
        sptla_pkg::rsp_t res;
        idx  = {r.section, r.step};
        base = {r.section, 4'd0};
        nxt  = {1'b0, r.step};
        if (r.cmd == sptla_pkg::CMD_PROG)
        begin
            flags[idx] = apply_switches(flags[idx], r.switch_lines);
        end
        else if (flags[idx][sptla_pkg::LAST_BIT])
        begin
            // walk back to the nearest first mark, never past the section start
            while (nxt != 0 && !flags[base + nxt][sptla_pkg::FIRST_BIT])
            begin
                nxt = nxt - 1;
            end
        end
        else
        begin
            nxt = {1'b0, r.step} + 5'd1;
            if (nxt > {1'b0, last_step} || nxt >= 5'd16) nxt = 5'd0;
        end
        res.follow_step = nxt[3:0];
        res.step_word   = flags[idx];
        awaited.push_back(res);
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_rsp(sptla_pkg::rsp_t got);
        sptla_pkg::rsp_t want;
        if (awaited.size() == 0)
        begin
            report($sformatf("result %h with nothing awaited", got));
        end
        else
        begin
            want = awaited.pop_front();
            if (got.follow_step !== want.follow_step)
                report($sformatf("follow_step %0d, expected %0d",
                    got.follow_step, want.follow_step));
            if (got.step_word !== want.step_word)
                report($sformatf("step_word %h, expected %h", got.step_word, want.step_word));
        end
    endtask
endclass

module testbench;
    import sptla_pkg::*;

    // switch line positions used by the directed items
    localparam int SW_V4          = 2;
    localparam int SW_V8          = 4;
    localparam int SW_FULL        = 5;
    localparam int SW_PULSE1_ON   = 6;
    localparam int SW_QUANT_ON    = 10;
    localparam int SW_SLOPED      = 12;
    localparam int SW_SRC_EXT     = 14;
    localparam int SW_STOP_OFF    = 17;
    localparam int SW_SUSTAIN_ON  = 18;
    localparam int SW_SUSTAIN_OFF = 19;
    localparam int SW_ENABLE_ON   = 20;
    localparam int SW_FIRST_ON    = 22;
    localparam int SW_FIRST_OFF   = 23;
    localparam int SW_LAST_ON     = 24;
    localparam int SW_LAST_OFF    = 25;
    localparam int SW_TSRC_EXT    = 26;
    localparam int SW_TR1         = 28;
    localparam int SW_TR4         = 31;

    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 306;
    localparam int CYCLE_LIMIT    = 1000000;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;        // no idling on either side while set
    int   cycles;
    int   rsp_hold;

    step_table_tracker tracker;

    sptla_chan_if #(.payload_t(req_t)) req_if ();
    sptla_chan_if #(.payload_t(rsp_t)) rsp_if ();
    sptla_chan_if #(.payload_t(cfg_t)) cfg_if ();

    step_program_table_with_loop_advance_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run guard: a stuck handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    // Mostly short stalls, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: ready with random stalls; a result is checked on acceptance.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            tracker.check_rsp(rsp_if.data);
        end
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= 0;
        end
        else if (rsp_hold != 0)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= rsp_hold - 1;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= gap_len() - 1;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Present one item and hold it until accepted; valid stays high afterward.
    task send_item(req_t r);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        tracker.note_req(r);
    endtask

    task sender_gap();
        int n;
        n = (calm || $urandom_range(0, 1)) ? 0 : gap_len();
        if (n != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off the sender until every awaited result is in.
    task drain();
        if (tracker.awaited.size() != 0)
        begin
            req_if.valid <= 1'b0;
            while (tracker.awaited.size() != 0) @(posedge clk);
        end
    endtask

    task write_last_step(logic [STEP_W-1:0] v);
        cfg_t c;
        c.last_step  = v;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= c;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        tracker.last_step = v;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic req_t prog_item(logic sec, logic [3:0] st, logic [31:0] presses);
        req_t r;
        r.cmd          = CMD_PROG;
        r.section      = sec;
        r.step         = st;
        r.switch_lines = ~presses;
        return r;
    endfunction

    function automatic req_t next_item(logic sec, logic [3:0] st);
        req_t r;
        r.cmd          = CMD_NEXT;
        r.section      = sec;
        r.step         = st;
        r.switch_lines = $urandom;   // ignored by an advance
        return r;
    endfunction

    task put(req_t r);
        send_item(r);
        sender_gap();
    endtask

    // Directed items at the reset value of last_step.
    task run_directed();
        put(prog_item(1'b0, 4'd0, 32'h0));              // nothing pressed
        put(prog_item(1'b1, 4'd15, 32'hFFFF_FFFF));     // every switch pressed
        put(prog_item(1'b0, 4'd3, (32'd1 << SW_V4) | (32'd1 << SW_PULSE1_ON)
            | (32'd1 << SW_QUANT_ON) | (32'd1 << SW_SLOPED) | (32'd1 << SW_SRC_EXT)
            | (32'd1 << SW_TSRC_EXT) | (32'd1 << SW_TR1)));
        put(prog_item(1'b0, 4'd3, 32'd1 << SW_SUSTAIN_ON));
        put(prog_item(1'b0, 4'd3, 32'd1 << SW_STOP_OFF));    // off for another mode
        put(prog_item(1'b0, 4'd3, 32'd1 << SW_SUSTAIN_OFF)); // off for its own mode
        put(prog_item(1'b0, 4'd7, (32'd1 << SW_V8) | (32'd1 << SW_FULL)
            | (32'd1 << SW_ENABLE_ON) | (32'd1 << SW_TR4)));
        put(prog_item(1'b0, 4'd2, 32'd1 << SW_FIRST_ON));
        put(prog_item(1'b0, 4'd5, 32'd1 << SW_LAST_ON));
        put(next_item(1'b0, 4'd5));                     // loop back to the first mark
        put(prog_item(1'b1, 4'd4, 32'd1 << SW_LAST_ON));
        put(next_item(1'b1, 4'd4));                     // no first mark in this section
        put(next_item(1'b0, 4'd15));                    // wrap at the section end
        put(next_item(1'b0, 4'd14));
        put(next_item(1'b1, 4'd0));
        put(prog_item(1'b0, 4'd2, 32'd1 << SW_FIRST_OFF));
        put(next_item(1'b0, 4'd5));
        put(prog_item(1'b0, 4'd0, 32'd1 << SW_FIRST_ON));
        put(next_item(1'b0, 4'd5));
        put(prog_item(1'b0, 4'd5, 32'd1 << SW_LAST_OFF));
        put(next_item(1'b0, 4'd5));
        put(prog_item(1'b1, 4'd0, 32'd1 << SW_LAST_ON));
        put(next_item(1'b1, 4'd0));                     // last mark at the section start
        put(prog_item(1'b1, 4'd0, 32'hFFFF_FFFF));
        put(next_item(1'b1, 4'd15));
    endtask

    // Mostly sparse presses so loop marks build up; some noise and extremes.
    function automatic req_t random_item();
        req_t        r;
        int          pick;
        logic [31:0] presses;
        if ($urandom_range(0, 99) < 55)
        begin
            r = next_item(1'($urandom), 4'($urandom));
        end
        else
        begin
            pick    = $urandom_range(0, 99);
            presses = '0;
            if (pick < 50)
            begin
                repeat ($urandom_range(1, 3)) presses[$urandom_range(0, 31)] = 1'b1;
            end
            else if (pick < 72)
            begin
                case ($urandom_range(0, 3))
                    0: presses[SW_FIRST_ON] = 1'b1;
                    1: presses[SW_LAST_ON] = 1'b1;
                    2: presses[SW_FIRST_OFF] = 1'b1;
                    default: presses[SW_LAST_OFF] = 1'b1;
                endcase
                if ($urandom_range(0, 1)) presses[$urandom_range(0, 31)] = 1'b1;
            end
            else if (pick < 92)
            begin
                presses = $urandom;
            end
            else
            begin
                presses = $urandom_range(0, 1) ? '0 : '1;
            end
            r = prog_item(1'($urandom), 4'($urandom), presses);
        end
        return r;
    endfunction

    initial
    begin
        logic [STEP_W-1:0] setting;
        tracker      = new();
        rst_n        = 1'b0;
        calm         = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Each phase runs under one last_step value, set while the block is idle.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: setting = 4'd0;
                1: setting = 4'd15;
                2: setting = 4'd7;
                3: setting = 4'($urandom);
                default: setting = 4'd1;
            endcase
            drain();
            write_last_step(setting);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // bursts with no idling; phase 2 runs flat out throughout
                calm = (p == 2) || (i % 100 < 20);
                if (p == 1 && i == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                put(random_item());
            end
        end
        calm = 1'b0;

        drain();
        repeat (40) @(posedge clk);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
